FILE: src/rrts_pkg.sv
// Shared request, status and result types for the round-robin thread scheduler.
package rrts_pkg;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_START   = 3'd1,
    REQ_YIELD   = 3'd2,
    REQ_BLOCK   = 3'd3,
    REQ_FINISH  = 3'd4,
    REQ_UNBLOCK = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DONE     = 2'd1,
    ST_DEADLOCK = 2'd2,
    ST_REJECT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] thread_id;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic       run_valid;
    logic [3:0] result_id;
  } result_t;

endpackage

FILE: src/round_robin_thread_scheduler.sv
// Round-robin thread scheduler top level: request register, core and result register.
//
// Requests enter on the in_ channel (in_req_type, in_thread_id) and each one
// produces exactly one result on the out_ channel (out_status, out_run_valid,
// out_result_id). A transfer happens on a rising edge with valid high and
// stall low on that channel.
// A request is captured in the request register, evaluated against the thread
// table and ready queue, and its result is held in the result register.
// One request is taken per cycle while the receiver does not stall; the
// combinational table update, queue push/pop and lowest-free-slot encode set
// that rate.
// When the receiver stalls, the result register holds its result and the
// request register still takes one more request; in_stall rises once both
// are occupied, and nothing is lost.
// Reset (rst_n low, synchronous) frees every thread slot, empties the ready
// queue, clears the running thread and the halted condition, and drops both
// valids. After an all-done or deadlock report every request is rejected
// until the next reset.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [3:0] in_thread_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_run_valid,
  output logic [3:0] out_result_id
);

  logic              req_valid_r;
  rrts_pkg::req_t    req_r;
  logic              res_valid_r;
  rrts_pkg::result_t res_r;
  rrts_pkg::result_t res;
  logic              advance;

  assign advance  = req_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;

  rrts_core #(
    .MAX_THREADS (MAX_THREADS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (advance),
    .req   (req_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
      end else if (!out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.req_type  <= in_req_type;
      req_r.thread_id <= in_thread_id;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_status    = res_r.status;
  assign out_run_valid = res_r.run_valid;
  assign out_result_id = res_r.result_id;

endmodule

FILE: src/rrts_ready_fifo.sv
// Circular queue of ready thread ids with a registered read of the head entry.
module rrts_ready_fifo #(
  parameter int DEPTH = 16,
  parameter int IDW   = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [IDW-1:0] push_id,
  input  logic           pop,
  output logic [IDW-1:0] head_id,
  output logic           empty
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [IDW-1:0] mem [DEPTH];
  logic [IDW-1:0] head_r, head_nxt;
  logic [IDW-1:0] tail_r, tail_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [IDW-1:0] rdata_r;
  logic [IDW-1:0] byp_data_r;
  logic           byp_sel_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop) begin
      head_nxt = (head_r == IDW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push) begin
      tail_nxt = (tail_r == IDW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      byp_sel_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      // A write landing on the entry that becomes the head is not yet in the
      // registered read, so it is forwarded for one cycle.
      byp_sel_r <= push && (tail_r == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_id;
    end
    rdata_r    <= mem[head_nxt];
    byp_data_r <= push_id;
  end

  assign head_id = byp_sel_r ? byp_data_r : rdata_r;
  assign empty   = (count_r == '0);

endmodule

FILE: src/rrts_core.sv
// Thread state table, running thread and the per-request scheduling decision.
module rrts_core #(
  parameter int MAX_THREADS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             exec,
  input  rrts_pkg::req_t   req,
  output rrts_pkg::result_t res
);

  localparam int IDW = $clog2(MAX_THREADS);

  // A thread slot is free, blocked, or (neither) ready or running.
  logic [MAX_THREADS-1:0] free_r, free_nxt;
  logic [MAX_THREADS-1:0] blocked_r, blocked_nxt;
  logic [IDW-1:0]         run_id_r, run_id_nxt;
  logic                   run_r, run_nxt;
  logic                   halted_r, halted_nxt;

  logic                   push, pop;
  logic [IDW-1:0]         push_id;
  logic [IDW-1:0]         head_id;
  logic                   fifo_empty;

  logic [IDW-1:0]         free_idx;
  logic [IDW-1:0]         tid_idx;
  logic                   tid_in_range;
  logic                   do_disp;
  logic                   created;
  rrts_pkg::status_e      status;
  logic [IDW-1:0]         rid;

  rrts_ready_fifo #(
    .DEPTH (MAX_THREADS),
    .IDW   (IDW)
  ) u_ready_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_id (push_id),
    .pop     (pop),
    .head_id (head_id),
    .empty   (fifo_empty)
  );

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = IDW'(i);
      end
    end
  end

  assign tid_idx      = IDW'(req.thread_id);
  assign tid_in_range = (32'(req.thread_id) < 32'(MAX_THREADS));

  always_comb begin
    free_nxt    = free_r;
    blocked_nxt = blocked_r;
    run_id_nxt  = run_id_r;
    run_nxt     = run_r;
    halted_nxt  = halted_r;
    push        = 1'b0;
    push_id     = '0;
    pop         = 1'b0;
    do_disp     = 1'b0;
    created     = 1'b0;
    status      = rrts_pkg::ST_REJECT;

    if (exec && !halted_r) begin
      unique case (req.req_type)
        rrts_pkg::REQ_CREATE: begin
          if (|free_r) begin
            free_nxt[free_idx] = 1'b0;
            push               = 1'b1;
            push_id            = free_idx;
            created            = 1'b1;
            status             = rrts_pkg::ST_OK;
          end
        end
        rrts_pkg::REQ_START: begin
          if (!run_r) begin
            do_disp = 1'b1;
          end
        end
        rrts_pkg::REQ_YIELD: begin
          // With nobody else ready the yielding thread simply keeps running.
          if (run_r) begin
            status = rrts_pkg::ST_OK;
            if (!fifo_empty) begin
              push       = 1'b1;
              push_id    = run_id_r;
              pop        = 1'b1;
              run_id_nxt = head_id;
            end
          end
        end
        rrts_pkg::REQ_BLOCK: begin
          if (run_r) begin
            blocked_nxt[run_id_r] = 1'b1;
            do_disp               = 1'b1;
          end
        end
        rrts_pkg::REQ_FINISH: begin
          if (run_r) begin
            free_nxt[run_id_r] = 1'b1;
            do_disp            = 1'b1;
          end
        end
        rrts_pkg::REQ_UNBLOCK: begin
          if (tid_in_range && blocked_r[tid_idx]) begin
            blocked_nxt[tid_idx] = 1'b0;
            push                 = 1'b1;
            push_id              = tid_idx;
            status               = rrts_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase

      if (do_disp) begin
        if (fifo_empty) begin
          run_nxt    = 1'b0;
          run_id_nxt = '0;
          halted_nxt = 1'b1;
          status     = (|blocked_nxt) ? rrts_pkg::ST_DEADLOCK : rrts_pkg::ST_DONE;
        end else begin
          pop        = 1'b1;
          run_nxt    = 1'b1;
          run_id_nxt = head_id;
          status     = rrts_pkg::ST_OK;
        end
      end
    end

    if (halted_r) begin
      rid = '0;
    end else if (created) begin
      rid = free_idx;
    end else if (run_nxt) begin
      rid = run_id_nxt;
    end else begin
      rid = '0;
    end

    res.status    = status;
    res.run_valid = halted_r ? 1'b0 : run_nxt;
    res.result_id = 4'(rid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r    <= '1;
      blocked_r <= '0;
      run_id_r  <= '0;
      run_r     <= 1'b0;
      halted_r  <= 1'b0;
    end else begin
      free_r    <= free_nxt;
      blocked_r <= blocked_nxt;
      run_id_r  <= run_id_nxt;
      run_r     <= run_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule
